### src/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared types, constants and functions of the MLP inference engine
// Holds the item layout, operation and register codes, saturation and the
// tanh lookup table that is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  localparam int MAX_LAYERS   = 4;
  localparam int MAX_WIDTH    = 64;
  localparam int DATA_WIDTH   = 16;
  localparam int TANH_ENTRIES = 256;
  localparam int FRAC_BITS    = 12;
  localparam int ACC_WIDTH    = 40;
  localparam int FIFO_DEPTH   = 4;

  localparam int LW = $clog2(MAX_LAYERS);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int TW = $clog2(TANH_ENTRIES);

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_WEIGHT  = 3'd0,
    OP_BIAS    = 3'd1,
    OP_MEAN    = 3'd2,
    OP_INV     = 3'd3,
    OP_FEATURE = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LAYER_COUNT = 3'd0,
    CFG_INPUT_WIDTH = 3'd1,
    CFG_HIDDEN1     = 3'd2,
    CFG_HIDDEN2     = 3'd3,
    CFG_HIDDEN3     = 3'd4,
    CFG_OUTPUT      = 3'd5,
    CFG_TANH_MASK   = 3'd6
  } cfg_idx_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_t                           op;
    logic [LW-1:0]                 lay;
    logic [AW-1:0]                 row;
    logic [AW-1:0]                 col;
    logic signed [DATA_WIDTH-1:0]  value;
  } item_t;

  typedef logic signed [DATA_WIDTH-1:0] tanh_lut_t [TANH_ENTRIES];

  // Clamp a wide signed value to the data range.
  function automatic logic signed [DATA_WIDTH-1:0] saturate(
    input logic signed [ACC_WIDTH-1:0] v
  );
    logic signed [ACC_WIDTH-1:0] hi;
    logic signed [ACC_WIDTH-1:0] lo;
    hi = ACC_WIDTH'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
    lo = -hi - ACC_WIDTH'(1);
    if (v > hi) return hi[DATA_WIDTH-1:0];
    if (v < lo) return lo[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1:0];
  endfunction

  // Quotient of two non-negative values by shift and subtract.
  function automatic longint udiv(input longint a, input longint b);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int k = 62; k >= 0; k--) begin
      r = (r <<< 1) | ((a >>> k) & 64'd1);
      q = q <<< 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Magnitude of tanh for table step mag, Q30 exponent series, Q12 result.
  function automatic longint tanh_mag(input longint mag);
    longint one;
    longint c;
    longint y16;
    longint n;
    longint rq;
    longint p;
    longint term;
    longint s;
    longint num;
    longint den;
    longint r;
    longint hi;
    one = longint'(1) <<< 30;
    c   = 947573834;
    y16 = (mag <<< (DATA_WIDTH + 5)) >>> TW;
    n   = y16 >>> 13;
    rq  = (y16 & 64'h1FFF) <<< 14;
    p   = one;
    s   = one;
    if (n >= 256) begin
      p = 0;
    end else begin
      for (longint i = 0; i < n; i++) p = (p * c) >>> 30;
      term = ((one * rq) >>> 30);
      s = s - term;
      term = udiv((term * rq) >>> 30, 2);
      s = s + term;
      term = udiv((term * rq) >>> 30, 3);
      s = s - term;
      term = udiv((term * rq) >>> 30, 4);
      s = s + term;
      term = udiv((term * rq) >>> 30, 5);
      s = s - term;
      p = (p * s) >>> 30;
    end
    num = one - p;
    den = one + p;
    r   = udiv(num * (longint'(1) <<< (FRAC_BITS + 1)) + den, 2 * den);
    hi  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Full odd table, indexed by the top bits of the offset value.
  function automatic tanh_lut_t build_tanh();
    tanh_lut_t t;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      if (k >= TANH_ENTRIES / 2)
        t[k] = DATA_WIDTH'(tanh_mag(longint'(k - TANH_ENTRIES / 2)));
      else
        t[k] = DATA_WIDTH'(-tanh_mag(longint'(TANH_ENTRIES / 2 - k)));
    end
    return t;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_tanh();

  // Clamp a 7-bit width register to 1..MAX_WIDTH.
  function automatic logic [CW-1:0] clamp_width(input logic [6:0] w);
    if (w == 7'd0) return CW'(1);
    if (w > 7'(MAX_WIDTH)) return CW'(MAX_WIDTH);
    return CW'(w);
  endfunction

endpackage

`default_nettype wire

### src/mie_fifo.sv
// ----------------------------------------------------------------------------
// mie_fifo: short item queue between front and back
// A few entries of registers with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_fifo
  import mie_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_data,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_data,
  output logic       empty
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  item_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == NW'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = do_push ? PW'(wp_r + PW'(1)) : wp_r;
    rp_nxt  = do_pop ? PW'(rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(FIFO_DEPTH)) else $error("queue count overflow");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - NW'(1)))
    else $error("queue pop lost");
  a_push_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + NW'(1)))
    else $error("queue push lost");

endmodule

`default_nettype wire

### src/mie_front.sv
// ----------------------------------------------------------------------------
// mie_front: input item acceptance and classification
// Decodes the operation, drops unknown codes and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_front
  import mie_pkg::*;
(
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_operation,
  input  wire logic [1:0]                    in_layer_index,
  input  wire logic [5:0]                    in_row_index,
  input  wire logic [5:0]                    in_col_index,
  input  wire logic signed [DATA_WIDTH-1:0]  in_value,
  output logic                               push,
  output item_t                              push_data,
  input  wire logic                          full
);

  logic known;

  // Only the five defined operations are queued; the others vanish.
  always_comb begin
    known = 1'b0;
    unique case (in_operation)
      OP_WEIGHT, OP_BIAS, OP_MEAN, OP_INV, OP_FEATURE: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_stall        = full;
  assign push            = in_valid && !full && known;
  assign push_data.op    = op_t'(in_operation);
  assign push_data.lay   = LW'(in_layer_index);
  assign push_data.row   = AW'(in_row_index);
  assign push_data.col   = AW'(in_col_index);
  assign push_data.value = in_value;

endmodule

`default_nettype wire

### src/mie_back.sv
// ----------------------------------------------------------------------------
// mie_back: memories, configuration and the sample evaluation sequencer
// Executes loads, collects features, standardizes them and runs each layer
// through one pipelined multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_back
  import mie_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_en,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [6:0]                    cfg_data,
  input  wire item_t                         item,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_value,
  output logic [5:0]                         out_index,
  output logic                               out_last
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_STD_RD    = 9'b000000010,
    S_STD_MUL   = 9'b000000100,
    S_STD_WR    = 9'b000001000,
    S_COL_START = 9'b000010000,
    S_COL_INIT  = 9'b000100000,
    S_MAC       = 9'b001000000,
    S_DRAIN     = 9'b010000000,
    S_FIN       = 9'b100000000
  } state_t;

  localparam int DW = DATA_WIDTH;

  // Configuration registers.
  logic [2:0] layer_count_r;
  logic [6:0] input_width_r, hid1_r, hid2_r, hid3_r, output_width_r;
  logic [3:0] tanh_mask_r;

  // Memories.
  logic signed [DW-1:0] wmem   [MAX_LAYERS*MAX_WIDTH*MAX_WIDTH];
  logic signed [DW-1:0] bmem   [MAX_LAYERS*MAX_WIDTH];
  logic signed [DW-1:0] mmem   [MAX_WIDTH];
  logic signed [DW-1:0] imem   [MAX_WIDTH];
  logic signed [DW-1:0] act_a  [MAX_WIDTH];
  logic signed [DW-1:0] act_b  [MAX_WIDTH];
  logic signed [DW-1:0] w_q, b_q, m_q, i_q, a_q, bq_act;

  // Sequencer state.
  state_t               state_r, state_nxt;
  logic [CW-1:0]        fc_r, fc_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [LW-1:0]        l_r, l_nxt;
  logic [CW-1:0]        n_in_r, n_in_nxt;
  logic                 p1_r, p1_nxt;
  logic                 p2_r;
  logic signed [2*DW-1:0]    prod_r;
  logic signed [2*DW:0]      std_prod_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic [5:0]           out_index_r;
  logic                 out_last_r;

  // Derived values.
  logic [CW-1:0]        n_in_cfg, n_out, fc_inc;
  logic [LW:0]          layers;
  logic                 last_layer, last_col, out_free, emit, fin_go;
  logic signed [DW-1:0] src_q, layer_r, layer_res;
  logic signed [DW:0]   diff;
  logic                 wr_a, wr_b;
  logic [AW-1:0]        wa_addr;
  logic signed [DW-1:0] wa_data;

  assign n_in_cfg = clamp_width(input_width_r);

  // Layer count clamped to 1..MAX_LAYERS.
  always_comb begin
    if (layer_count_r == 3'd0) layers = (LW+1)'(1);
    else if (layer_count_r > 3'(MAX_LAYERS)) layers = (LW+1)'(MAX_LAYERS);
    else layers = (LW+1)'(layer_count_r);
  end

  assign last_layer = ((LW+1)'(l_r) + (LW+1)'(1) >= layers);

  // Output width of the current layer.
  always_comb begin
    if (last_layer) n_out = clamp_width(output_width_r);
    else begin
      unique case (l_r)
        2'd0:    n_out = clamp_width(hid1_r);
        2'd1:    n_out = clamp_width(hid2_r);
        default: n_out = clamp_width(hid3_r);
      endcase
    end
  end

  assign last_col = (j_r + CW'(1) == n_out);
  assign out_free = !out_valid_r || !out_stall;
  assign fin_go   = !last_layer || out_free;
  assign emit     = (state_r == S_FIN) && last_layer && out_free;
  assign fc_inc   = fc_r + CW'(1);
  assign pop      = (state_r == S_IDLE) && !empty;
  assign src_q    = l_r[0] ? bq_act : a_q;
  assign diff     = (DW+1)'(a_q) - (DW+1)'(m_q);

  // Layer result: shift, saturate, optional tanh.
  always_comb begin
    layer_r = saturate(acc_r >>> FRAC_BITS);
    if (tanh_mask_r[l_r]) layer_res = TANH_LUT[{~layer_r[DW-1], layer_r[DW-2 -: TW-1]}];
    else layer_res = layer_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r  <= 3'd1;
      input_width_r  <= 7'd1;
      hid1_r         <= 7'd1;
      hid2_r         <= 7'd1;
      hid3_r         <= 7'd1;
      output_width_r <= 7'd1;
      tanh_mask_r    <= 4'd0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_LAYER_COUNT: layer_count_r  <= cfg_data[2:0];
        CFG_INPUT_WIDTH: input_width_r  <= cfg_data;
        CFG_HIDDEN1:     hid1_r         <= cfg_data;
        CFG_HIDDEN2:     hid2_r         <= cfg_data;
        CFG_HIDDEN3:     hid3_r         <= cfg_data;
        CFG_OUTPUT:      output_width_r <= cfg_data;
        CFG_TANH_MASK:   tanh_mask_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    fc_nxt    = fc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    l_nxt     = l_r;
    n_in_nxt  = n_in_r;
    p1_nxt    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop && item.op == OP_FEATURE) begin
          if (fc_inc >= n_in_cfg) begin
            fc_nxt    = '0;
            i_nxt     = '0;
            n_in_nxt  = n_in_cfg;
            state_nxt = S_STD_RD;
          end else begin
            fc_nxt = fc_inc;
          end
        end
      end
      S_STD_RD:  state_nxt = S_STD_MUL;
      S_STD_MUL: state_nxt = S_STD_WR;
      S_STD_WR: begin
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == n_in_r) begin
          l_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_COL_START;
        end else begin
          state_nxt = S_STD_RD;
        end
      end
      S_COL_START: state_nxt = S_COL_INIT;
      S_COL_INIT: begin
        i_nxt     = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        p1_nxt = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (i_r + CW'(1) == n_in_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!p1_r && !p2_r) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          if (last_col) begin
            j_nxt = '0;
            if (last_layer) begin
              state_nxt = S_IDLE;
            end else begin
              l_nxt     = l_r + LW'(1);
              n_in_nxt  = n_out;
              state_nxt = S_COL_START;
            end
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_COL_START;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fc_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      l_r     <= '0;
      n_in_r  <= CW'(1);
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      l_r     <= l_nxt;
      n_in_r  <= n_in_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p1_r;
    end
  end

  // Arithmetic datapath: standardize product, MAC pipeline, accumulator.
  always_ff @(posedge clk) begin
    if (state_r == S_STD_MUL) std_prod_r <= diff * i_q;
    if (p1_r) prod_r <= w_q * src_q;
    if (state_r == S_COL_INIT) acc_r <= ACC_WIDTH'(b_q) <<< FRAC_BITS;
    else if (p2_r) acc_r <= acc_r + ACC_WIDTH'(prod_r);
  end

  // Load memories: weight, bias, mean and inverse scale.
  always_ff @(posedge clk) begin
    if (pop && item.op == OP_WEIGHT) wmem[{item.lay, item.row, item.col}] <= item.value;
    if (pop && item.op == OP_BIAS)   bmem[{item.lay, item.col}] <= item.value;
    if (pop && item.op == OP_MEAN)   mmem[item.row] <= item.value;
    if (pop && item.op == OP_INV)    imem[item.row] <= item.value;
    w_q <= wmem[{l_r, i_r[AW-1:0], j_r[AW-1:0]}];
    b_q <= bmem[{l_r, j_r[AW-1:0]}];
    m_q <= mmem[i_r[AW-1:0]];
    i_q <= imem[i_r[AW-1:0]];
  end

  // Activation write selection.
  always_comb begin
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    wa_addr = j_r[AW-1:0];
    wa_data = layer_res;
    if (pop && item.op == OP_FEATURE && fc_r < CW'(MAX_WIDTH)) begin
      wr_a    = 1'b1;
      wa_addr = fc_r[AW-1:0];
      wa_data = item.value;
    end else if (state_r == S_STD_WR) begin
      wr_a    = 1'b1;
      wa_addr = i_r[AW-1:0];
      wa_data = saturate(ACC_WIDTH'(std_prod_r >>> FRAC_BITS));
    end else if (state_r == S_FIN && fin_go) begin
      wr_a = l_r[0];
      wr_b = !l_r[0];
    end
  end

  // Activation ping-pong buffers.
  always_ff @(posedge clk) begin
    if (wr_a) act_a[wa_addr] <= wa_data;
    if (wr_b) act_b[j_r[AW-1:0]] <= layer_res;
    a_q    <= act_a[i_r[AW-1:0]];
    bq_act <= act_b[i_r[AW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= layer_res;
      out_index_r <= 6'(j_r);
      out_last_r  <= last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

  a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (i_r < n_in_r)) else $error("MAC index past layer input");
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (!p1_r && !p2_r)) else $error("result taken before MAC drain");
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r < CW'(MAX_WIDTH)) else $error("feature count out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE)) else $error("item taken while busy");

endmodule

`default_nettype wire

### src/mlp_inference_engine.sv
// ----------------------------------------------------------------------------
// mlp_inference_engine: dense feed-forward network evaluator, Q4.12
// Front end classifies items into a short queue; the back end loads the
// memories and evaluates a sample once all of its features are in.
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  in       in_valid/in_stall, operation..value           item in
//  out      out_valid/out_stall, out_value/index/last     result out
//  cfg      cfg_write_en, cfg_index, cfg_data             register write
//
// Load and feature items are handled while the back end is idle. The item
// that completes a sample is standardized feature by feature, and then
// each layer is run in the single shared multiply-accumulate unit.
// Reset clears control state and sets the register defaults; the memories
// hold no reset value. A stalled output holds back the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_inference_engine
  import mie_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_operation,
  input  wire logic [1:0]                    in_layer_index,
  input  wire logic [5:0]                    in_row_index,
  input  wire logic [5:0]                    in_col_index,
  input  wire logic signed [DATA_WIDTH-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_value,
  output logic [5:0]                         out_index,
  output logic                               out_last,
  input  wire logic                          cfg_write_en,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [6:0]                    cfg_data
);

  item_t push_data, pop_data;
  logic  push, full, pop, empty;

  // Item intake.
  mie_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_layer_index (in_layer_index),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_value       (in_value),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  // Queue between the two halves.
  mie_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Execution.
  mie_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (pop_data),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_index    (out_index),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

### tb/mlp_inference_engine_tb.sv
// ----------------------------------------------------------------------------
// mlp_inference_engine_tb: self-checking testbench of the MLP inference engine
// Loads the weight, bias, mean and inverse-scale memories, streams feature
// items under several network shapes and compares every result element with
// a local fixed-point model of the network, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_inference_engine_tb
  import mie_pkg::*;
();

  // Expected result element.
  typedef struct {
    logic signed [15:0] value;
    logic [5:0]         index;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_operation;
  logic [1:0]         in_layer_index;
  logic [5:0]         in_row_index;
  logic [5:0]         in_col_index;
  logic signed [15:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_value;
  logic [5:0]         out_index;
  logic               out_last;
  logic               cfg_write_en;
  logic [2:0]         cfg_index;
  logic [6:0]         cfg_data;

  // Network model state.
  logic signed [15:0] weight_mem [4*64*64];
  logic signed [15:0] bias_mem [4*64];
  logic signed [15:0] mean_mem [64];
  logic signed [15:0] scale_mem [64];
  bit                 weight_ok [4*64*64];
  bit                 bias_ok [4*64];
  bit                 mean_ok [64];
  bit                 scale_ok [64];
  int                 act [2][64];
  int                 feature_cnt;
  int                 tanh_tab [256];
  logic [6:0]         regs [7];

  result_t            pending_results [$];
  int                 fail_count;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 hold_request;

  mlp_inference_engine u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_layer_index(in_layer_index),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_index     (out_index),
    .out_last      (out_last),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Clamp to the signed 16-bit range.
  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clamp_count(input int w, input int top);
    if (w == 0) return 1;
    return (w > top) ? top : w;
  endfunction

  // Magnitude of tanh at table step m: exp(-2|x|) as a power of exp(-1/8).
  function automatic longint tanh_step(input longint m);
    longint one, y16, n, rq, p, term, s, num, den;
    one  = longint'(1) << 30;
    y16  = (m << 21) / 256;
    n    = y16 >> 13;
    rq   = (y16 & 'h1FFF) << 14;
    p    = one;
    term = one;
    s    = one;
    if (n >= 256) begin
      p = 0;
    end else begin
      for (longint i = 0; i < n; i++) p = (p * 947573834) >>> 30;
      for (int k = 1; k <= 5; k++) begin
        term = ((term * rq) >>> 30) / k;
        s = (k % 2 == 1) ? s - term : s + term;
      end
      p = (p * s) >>> 30;
    end
    num = one - p;
    den = one + p;
    return sat16((num * 8192 + den) / (2 * den));
  endfunction

  function automatic int layer_width(input int l, input int layers);
    if (l + 1 >= layers) return clamp_count(regs[CFG_OUTPUT], 64);
    if (l == 0) return clamp_count(regs[CFG_HIDDEN1], 64);
    if (l == 1) return clamp_count(regs[CFG_HIDDEN2], 64);
    return clamp_count(regs[CFG_HIDDEN3], 64);
  endfunction

  // Apply one accepted item to the network model; queue any results.
  function automatic void apply_item(input logic [2:0] op, input logic [1:0] lay,
                                     input logic [5:0] row, input logic [5:0] col,
                                     input logic signed [15:0] val);
    int      n_in, n_out, layers, src;
    longint  acc, r;
    result_t res;
    n_out = 1;
    src   = 0;
    case (op)
      OP_WEIGHT: begin
        weight_mem[{lay, row, col}] = val;
        weight_ok[{lay, row, col}]  = 1'b1;
      end
      OP_BIAS: begin
        bias_mem[{lay, col}] = val;
        bias_ok[{lay, col}]  = 1'b1;
      end
      OP_MEAN: begin
        mean_mem[row] = val;
        mean_ok[row]  = 1'b1;
      end
      OP_INV: begin
        scale_mem[row] = val;
        scale_ok[row]  = 1'b1;
      end
      OP_FEATURE: begin
        if (feature_cnt < 64) act[0][feature_cnt] = val;
        feature_cnt = (feature_cnt + 1) & 127;
        n_in = clamp_count(regs[CFG_INPUT_WIDTH], 64);
        if (feature_cnt >= n_in) begin
          feature_cnt = 0;
          // Standardize the features.
          for (int i = 0; i < n_in; i++)
            act[0][i] = int'(sat16(((longint'(act[0][i]) - mean_mem[i]) * scale_mem[i])
                                   >>> 12));
          // Dense layers, ping-ponging between the two activation buffers.
          layers = clamp_count(regs[CFG_LAYER_COUNT], 4);
          for (int l = 0; l < layers; l++) begin
            n_out = layer_width(l, layers);
            for (int j = 0; j < n_out; j++) begin
              acc = longint'(bias_mem[l*64 + j]) * 4096;
              for (int i = 0; i < n_in; i++)
                acc += longint'(weight_mem[(l*64 + i)*64 + j]) * act[src][i];
              r = sat16(acc >>> 12);
              if (regs[CFG_TANH_MASK][l]) r = tanh_tab[(r + 32768) >> 8];
              act[1-src][j] = int'(r);
            end
            src  = 1 - src;
            n_in = n_out;
          end
          for (int j = 0; j < n_out; j++) begin
            res.value = 16'(act[src][j]);
            res.index = 6'(j);
            res.last  = (j + 1 == n_out);
            pending_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mixed value: mostly moderate, sometimes anything, sometimes an extreme.
  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 16'($urandom);
    if (r == 1) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return 16'($urandom_range(4096) - 2048);
  endfunction

  // Offer one item and wait until the block takes it.
  task automatic send_item(input logic [2:0] op, input logic [1:0] lay,
                           input logic [5:0] row, input logic [5:0] col,
                           input logic [15:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_layer_index <= lay;
    in_row_index   <= row;
    in_col_index   <= col;
    in_value       <= val;
    do @(posedge clk); while (in_stall);
    apply_item(op, lay, row, col, val);
  endtask

  // Drop valid, let every result arrive, then let the back end settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input int v);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= 7'(v);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    regs[idx] = (idx == CFG_LAYER_COUNT) ? 7'(v & 7) :
                (idx == CFG_TANH_MASK) ? 7'(v & 15) : 7'(v);
  endtask

  task automatic set_shape(input int layers, input int n_in, input int h1, input int h2,
                           input int h3, input int n_out, input int mask);
    set_reg(CFG_LAYER_COUNT, layers);
    set_reg(CFG_INPUT_WIDTH, n_in);
    set_reg(CFG_HIDDEN1, h1);
    set_reg(CFG_HIDDEN2, h2);
    set_reg(CFG_HIDDEN3, h3);
    set_reg(CFG_OUTPUT, n_out);
    set_reg(CFG_TANH_MASK, mask);
  endtask

  // Write every memory entry the current shape reads that was never written.
  task automatic load_missing();
    int n_in, n_out, layers;
    n_in   = clamp_count(regs[CFG_INPUT_WIDTH], 64);
    layers = clamp_count(regs[CFG_LAYER_COUNT], 4);
    for (int i = 0; i < n_in; i++) begin
      if (!mean_ok[i]) send_item(OP_MEAN, 2'($urandom), 6'(i), 6'($urandom), pick_value());
      if (!scale_ok[i]) send_item(OP_INV, 2'($urandom), 6'(i), 6'($urandom), pick_value());
    end
    for (int l = 0; l < layers; l++) begin
      n_out = layer_width(l, layers);
      for (int j = 0; j < n_out; j++) begin
        if (!bias_ok[l*64 + j])
          send_item(OP_BIAS, 2'(l), 6'($urandom), 6'(j), pick_value());
        for (int i = 0; i < n_in; i++)
          if (!weight_ok[(l*64 + i)*64 + j])
            send_item(OP_WEIGHT, 2'(l), 6'(i), 6'(j), pick_value());
      end
      n_in = n_out;
    end
  endtask

  // Random traffic: mostly features, reloads with random content, some noise.
  task automatic random_items(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 60)
        send_item(OP_FEATURE, 2'($urandom), 6'($urandom), 6'($urandom), pick_value());
      else if (r < 92)
        send_item(3'($urandom_range(3)), 2'($urandom), 6'($urandom), 6'($urandom),
                  pick_value());
      else
        send_item(3'($urandom_range(5, 7)), 2'($urandom), 6'($urandom), 6'($urandom),
                  16'($urandom));
    end
  endtask

  // Single-element network: extremes, ignored codes, tanh saturation.
  task automatic test_directed();
    load_missing();
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h7FFF);
    send_item(OP_FEATURE, 2'd3, 6'd63, 6'd63, 16'h8000);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h0000);
    send_item(3'd5, 2'd3, 6'd63, 6'd63, 16'hFFFF);
    send_item(3'd6, 2'd0, 6'd0, 6'd0, 16'h0000);
    send_item(3'd7, 2'd1, 6'd21, 6'd42, 16'h5555);
    send_item(OP_WEIGHT, 2'd3, 6'd63, 6'd63, 16'hFFFF);
    send_item(OP_WEIGHT, 2'd0, 6'd0, 6'd0, 16'h7FFF);
    send_item(OP_BIAS, 2'd0, 6'd63, 6'd0, 16'h8000);
    send_item(OP_MEAN, 2'd0, 6'd0, 6'd63, 16'h8000);
    send_item(OP_INV, 2'd0, 6'd0, 6'd0, 16'h7FFF);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h7FFF);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h8000);
    set_reg(CFG_TANH_MASK, 1);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h7FFF);
    send_item(OP_INV, 2'd0, 6'd0, 6'd0, 16'h1000);
    send_item(OP_MEAN, 2'd0, 6'd0, 6'd0, 16'h0000);
    send_item(OP_BIAS, 2'd0, 6'd0, 6'd0, 16'h0000);
    send_item(OP_WEIGHT, 2'd0, 6'd0, 6'd0, 16'h1000);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h8000);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'h0100);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'hFF00);
    wait_idle();
  endtask

  // Four layers with mixed widths and tanh everywhere.
  task automatic test_deep_network();
    set_shape(4, 2, 3, 1, 2, 2, 15);
    load_missing();
    random_items(40);
    wait_idle();
  endtask

  // Wide input; layer count zero means one layer.
  task automatic test_wide_input();
    set_shape(0, 32, 1, 1, 1, 1, 1);
    load_missing();
    for (int k = 0; k < 32; k++)
      send_item(OP_FEATURE, 2'($urandom), 6'($urandom), 6'($urandom), pick_value());
    wait_idle();
  endtask

  // Widest output, clamped from above; a long output hold fills the block.
  task automatic test_wide_output();
    set_shape(1, 1, 1, 1, 1, 127, 0);
    load_missing();
    hold_request = 400;
    for (int k = 0; k < 8; k++)
      send_item(OP_FEATURE, 2'($urandom), 6'($urandom), 6'($urandom), pick_value());
    random_items(10);
    wait_idle();
  endtask

  // Out-of-range register values are clamped; the sender also pauses to drain.
  task automatic test_clamped_regs();
    set_shape(7, 2, 0, 1, 1, 1, 10);
    load_missing();
    random_items(15);
    wait_idle();
    random_items(15);
    wait_idle();
  endtask

  // Input width lowered while a sample is partly collected.
  task automatic test_width_shrink();
    set_shape(1, 4, 1, 1, 1, 3, 0);
    load_missing();
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, pick_value());
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, pick_value());
    set_reg(CFG_INPUT_WIDTH, 1);
    send_item(OP_FEATURE, 2'd0, 6'd0, 6'd0, pick_value());
    random_items(10);
    wait_idle();
  endtask

  // Receiver: random stalls, or a counted hold when one is requested.
  always @(posedge clk) begin
    static int hold_left = 0;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker against the oldest expected element.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_value %0d out_index %0d", out_value, out_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, actual %0d", want.value, out_value);
          fail_count++;
        end
        if (out_index !== want.index) begin
          $error("out_index: expected %0d, actual %0d", want.index, out_index);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = '0;
    in_layer_index = '0;
    in_row_index   = '0;
    in_col_index   = '0;
    in_value       = '0;
    out_stall      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    fail_count     = 0;
    hold_request   = 0;
    feature_cnt    = 0;
    regs = '{7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0};
    for (int k = 0; k < 256; k++)
      tanh_tab[k] = int'((k >= 128) ? tanh_step(k - 128) : -tanh_step(128 - k));

    // Sender idles often, receiver stalls most of the time.
    send_idle_pct  = 28;
    recv_stall_pct = 85;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_deep_network();
    // Now the other way round.
    send_idle_pct  = 85;
    recv_stall_pct = 28;
    test_wide_input();
    test_wide_output();
    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_clamped_regs();
    test_width_shrink();

    wait_idle();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
src/mie_pkg.sv
src/mie_fifo.sv
src/mie_front.sv
src/mie_back.sv
src/mlp_inference_engine.sv
tb/mlp_inference_engine_tb.sv
